// ----- sv/rgb_to_hsv_pixel_defines.svh -----
// Assertion macros shared by the RGB to HSV pixel converter.
`ifndef RGB_TO_HSV_PIXEL_DEFINES_SVH
`define RGB_TO_HSV_PIXEL_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define RHSV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the following cycle.
`define RHSV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/rhsv_pkg.sv -----
// Types and constants of the RGB to HSV pixel converter.
package rhsv_pkg;

    localparam int CHAN_W = 8;
    localparam int HUE_W  = 9;
    localparam int QUO_W  = 6;
    localparam int DIVD_W = CHAN_W + QUO_W;

    localparam logic [HUE_W-1:0] HUE_BASE_BLUE  = 9'd60;
    localparam logic [HUE_W-1:0] HUE_BASE_GREEN = 9'd300;
    localparam logic [HUE_W-1:0] HUE_BASE_RED   = 9'd180;
    localparam logic [QUO_W-1:0] HUE_SCALE      = 6'd60;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } t_pixel;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [CHAN_W-1:0] saturation;
        logic [CHAN_W-1:0] brightness;
    } t_hsv;

    // Work carried along the divider chain
    typedef struct packed {
        logic [CHAN_W-1:0] rem;
        logic [QUO_W-1:0]  low;
        logic [QUO_W-1:0]  quo;
        logic [CHAN_W-1:0] span;
        logic [CHAN_W-1:0] brightness;
        logic [HUE_W-1:0]  base;
        logic              neg;
    } t_cell;

endpackage

// ----- sv/rhsv_front.sv -----
// Front cell: finds min, max, hue sector and the scaled difference.
module rhsv_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  rhsv_pkg::t_pixel   i_pixel,
    output logic               o_valid,
    output rhsv_pkg::t_cell    o_data
);
    import rhsv_pkg::*;

    logic              r_valid;
    t_cell             r_data;
    t_cell             n_data;
    logic [CHAN_W-1:0] s_min;
    logic [CHAN_W-1:0] s_max;
    logic [CHAN_W-1:0] s_pos;
    logic [CHAN_W-1:0] s_sub;
    logic [CHAN_W-1:0] s_mag;
    logic [HUE_W-1:0]  s_base;
    logic [DIVD_W-1:0] s_divd;

    // Pick the sector from the smallest channel, blue then green on ties
    always_comb begin
        if (i_pixel.blue <= i_pixel.green && i_pixel.blue <= i_pixel.red) begin
            s_min  = i_pixel.blue;
            s_pos  = i_pixel.green;
            s_sub  = i_pixel.red;
            s_base = HUE_BASE_BLUE;
        end else if (i_pixel.green <= i_pixel.red) begin
            s_min  = i_pixel.green;
            s_pos  = i_pixel.red;
            s_sub  = i_pixel.blue;
            s_base = HUE_BASE_GREEN;
        end else begin
            s_min  = i_pixel.red;
            s_pos  = i_pixel.blue;
            s_sub  = i_pixel.green;
            s_base = HUE_BASE_RED;
        end
        s_max = i_pixel.blue;
        if (i_pixel.green > s_max) s_max = i_pixel.green;
        if (i_pixel.red > s_max)   s_max = i_pixel.red;
    end

    // Scale the difference magnitude by 60 and split it for the divider
    always_comb begin
        s_mag             = (s_pos >= s_sub) ? s_pos - s_sub : s_sub - s_pos;
        s_divd            = DIVD_W'(s_mag) * DIVD_W'(HUE_SCALE);
        n_data.base       = s_base;
        n_data.neg        = s_pos < s_sub;
        n_data.span       = s_max - s_min;
        n_data.brightness = s_max;
        n_data.rem        = s_divd[DIVD_W-1:QUO_W];
        n_data.low        = s_divd[QUO_W-1:0];
        n_data.quo        = '0;
    end

    // Advance the stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- sv/rhsv_div_cell.sv -----
// Divider cell: resolves one quotient bit of the hue offset.
`include "rgb_to_hsv_pixel_defines.svh"

module rhsv_div_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  rhsv_pkg::t_cell    i_data,
    output logic               o_valid,
    output rhsv_pkg::t_cell    o_data
);
    import rhsv_pkg::*;

    logic            r_valid;
    t_cell           r_data;
    t_cell           n_data;
    logic [CHAN_W:0] s_trial;
    logic            s_ge;

    // Bring down the next dividend bit and try a subtract
    always_comb begin
        n_data      = i_data;
        s_trial     = {i_data.rem, i_data.low[QUO_W-1]};
        s_ge        = s_trial >= {1'b0, i_data.span};
        n_data.rem  = s_ge ? CHAN_W'(s_trial - {1'b0, i_data.span}) : s_trial[CHAN_W-1:0];
        n_data.low  = {i_data.low[QUO_W-2:0], 1'b0};
        n_data.quo  = {i_data.quo[QUO_W-2:0], s_ge};
    end

    // Advance the stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

    `RHSV_ASSERT_NOW(a_rem_below_span, r_valid && r_data.span != '0,
        r_data.rem < r_data.span, "divider remainder not below span")
    `RHSV_ASSERT_NEXT(a_hold_on_stall, !i_en, $stable(r_valid),
        "divider cell moved while stalled")

endmodule

// ----- sv/rgb_to_hsv_pixel.sv -----
// Top level of the RGB to HSV pixel converter.
//
// Input channel i_valid / o_ready carries one blue, green, red pixel per beat.
// Output channel o_valid / i_ready carries hue (0..360 degrees, floored),
// saturation (max minus min) and brightness (max) per beat, in input order.
// A front cell finds the extreme channels and scales the hue difference by 60,
// six identical divider cells each settle one quotient bit, and an output
// register forms the hue from the sector base and the quotient.
// Throughput is one pixel per cycle through the chain of eight registers while
// the receiver does not stall it.
// A gray pixel (all channels equal) gives hue 0.
// When the receiver holds i_ready low with a result waiting, the whole chain
// freezes and o_ready drops until the output register is taken.
// Synchronous reset clears every valid bit; the block takes a pixel in the
// first cycle after reset is released.
`include "rgb_to_hsv_pixel_defines.svh"

module rgb_to_hsv_pixel (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  rhsv_pkg::t_pixel  i_pixel,
    output logic              o_valid,
    input  logic              i_ready,
    output rhsv_pkg::t_hsv    o_hsv
);
    import rhsv_pkg::*;

    localparam int NCELL = QUO_W;

    logic              s_en;
    logic              s_valid [NCELL+1];
    t_cell             s_chain [NCELL+1];
    logic              r_out_valid;
    t_hsv              r_out;
    t_hsv              n_out;
    t_cell             s_last;

    // Move the chain whenever the output slot is free or being taken
    assign s_en    = !r_out_valid || i_ready;
    assign o_ready = s_en;

    rhsv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s_en),
        .i_valid (i_valid),
        .i_pixel (i_pixel),
        .o_valid (s_valid[0]),
        .o_data  (s_chain[0])
    );

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        rhsv_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (s_en),
            .i_valid (s_valid[k]),
            .i_data  (s_chain[k]),
            .o_valid (s_valid[k+1]),
            .o_data  (s_chain[k+1])
        );
    end

    // Form hue: base plus floored offset, zero for gray
    always_comb begin
        s_last           = s_chain[NCELL];
        n_out.saturation = s_last.span;
        n_out.brightness = s_last.brightness;
        if (s_last.span == '0) begin
            n_out.hue = '0;
        end else if (s_last.neg) begin
            n_out.hue = s_last.base - HUE_W'(s_last.quo)
                        - HUE_W'(s_last.rem != '0);
        end else begin
            n_out.hue = s_last.base + HUE_W'(s_last.quo);
        end
    end

    // Hold the result until the receiver takes the beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_en) begin
            r_out_valid <= s_valid[NCELL];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_hsv   = r_out;

    `RHSV_ASSERT_NOW(a_gray_hue_zero, r_out_valid && r_out.saturation == '0,
        r_out.hue == '0, "gray pixel with nonzero hue")
    `RHSV_ASSERT_NOW(a_hue_range, r_out_valid, r_out.hue <= 9'd360,
        "hue above 360")
    `RHSV_ASSERT_NOW(a_sat_le_max, r_out_valid, r_out.saturation <= r_out.brightness,
        "saturation above brightness")

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the RGB to HSV pixel converter.
`timescale 1ns / 100ps

module tb;
    import rhsv_pkg::*;

    localparam int RST_CYCLES   = 7;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 24;
    localparam int PHASE_ITEMS  = 640;

    // Hue sector bases, picked by the smallest channel
    localparam int BASE_BLUE_LOW  = 60;
    localparam int BASE_GREEN_LOW = 300;
    localparam int BASE_RED_LOW   = 180;
    localparam int DEG_PER_SECTOR = 60;

    typedef enum logic [1:0] {
        SECT_BLUE,
        SECT_GREEN,
        SECT_RED
    } t_sector;

    logic   i_clk   = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_valid = 1'b0;
    logic   o_ready;
    t_pixel i_pixel = '0;
    logic   o_valid;
    logic   i_ready = 1'b0;
    t_hsv   o_hsv;

    t_hsv exp_hsv_q[$];
    int   hsv_mismatches = 0;
    int   send_idle_pct  = 0;
    int   recv_idle_pct  = 0;
    int   hold_asked     = 0;
    int   hold_done      = 0;
    int   hold_left      = 0;
    int   quiet_cycles   = 0;

    rgb_to_hsv_pixel i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_pixel (i_pixel),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_hsv   (o_hsv)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Compute hue, saturation and brightness of one pixel
    function automatic t_hsv hsv_of(t_pixel px);
        int      b;
        int      g;
        int      r;
        int      lo;
        int      hi;
        int      span;
        int      base;
        int      diff;
        int      num;
        int      hue;
        t_sector sect;
        t_hsv    res;
        b    = px.blue;
        g    = px.green;
        r    = px.red;
        lo   = b;
        hi   = b;
        sect = SECT_BLUE;
        // ties for the minimum go to blue, then green
        if (g < lo) begin
            lo   = g;
            sect = SECT_GREEN;
        end
        if (r < lo) begin
            lo   = r;
            sect = SECT_RED;
        end
        if (g > hi) hi = g;
        if (r > hi) hi = r;
        span = hi - lo;
        case (sect)
            SECT_BLUE: begin
                base = BASE_BLUE_LOW;
                diff = g - r;
            end
            SECT_GREEN: begin
                base = BASE_GREEN_LOW;
                diff = r - b;
            end
            default: begin
                base = BASE_RED_LOW;
                diff = b - g;
            end
        endcase
        // gray pixel: no division, hue is zero
        hue = 0;
        if (span != 0) begin
            num = base * span + DEG_PER_SECTOR * diff;
            if (num < 0) num = 0;
            hue = num / span;
        end
        res.hue        = hue[HUE_W-1:0];
        res.saturation = span[CHAN_W-1:0];
        res.brightness = hi[CHAN_W-1:0];
        return res;
    endfunction

    function automatic t_pixel pix(int b, int g, int r);
        t_pixel px;
        px.blue  = b[CHAN_W-1:0];
        px.green = g[CHAN_W-1:0];
        px.red   = r[CHAN_W-1:0];
        return px;
    endfunction

    // Random pixel, weighted toward gray, ties and narrow spans
    function automatic t_pixel rand_pixel();
        int v;
        int kind;
        t_pixel px;
        v    = $urandom_range(0, 255);
        kind = $urandom_range(0, 9);
        px   = pix($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
        case (kind)
            0: px = pix(v, v, v);
            1: px.blue = px.green;
            2: px.blue = px.red;
            3: px.green = px.red;
            4: px = pix(v, (v + $urandom_range(0, 2)) % 256, (v + $urandom_range(0, 2)) % 256);
            default: ;
        endcase
        return px;
    endfunction

    // Offer one beat, with random gaps before it, and hold it until taken
    task automatic send_pixel(t_pixel px);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= px;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_done != hold_asked) begin
            hold_done <= hold_asked;
            hold_left <= HOLD_CYCLES;
            i_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Record expectations on input beats, compare output beats
    always @(posedge i_clk) begin
        t_hsv want;
        if (i_rst_n) begin
            if (i_valid && o_ready) exp_hsv_q.push_back(hsv_of(i_pixel));
            if (o_valid && i_ready) begin
                if (exp_hsv_q.size() == 0) begin
                    $error("unexpected result beat: hue %0d sat %0d bright %0d",
                           o_hsv.hue, o_hsv.saturation, o_hsv.brightness);
                    hsv_mismatches++;
                end else begin
                    want = exp_hsv_q.pop_front();
                    if (o_hsv.hue !== want.hue) begin
                        $error("hue: expected %0d, got %0d", want.hue, o_hsv.hue);
                        hsv_mismatches++;
                    end
                    if (o_hsv.saturation !== want.saturation) begin
                        $error("saturation: expected %0d, got %0d",
                               want.saturation, o_hsv.saturation);
                        hsv_mismatches++;
                    end
                    if (o_hsv.brightness !== want.brightness) begin
                        $error("brightness: expected %0d, got %0d",
                               want.brightness, o_hsv.brightness);
                        hsv_mismatches++;
                    end
                end
            end
        end
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAIL rgb_to_hsv_pixel");
                $finish;
            end
        end
    end

    // Gray, pure colors, ties for the minimum, unit spans, every sector
    task automatic test_corners();
        send_pixel(pix(0, 0, 0));
        send_pixel(pix(255, 255, 255));
        send_pixel(pix(128, 128, 128));
        send_pixel(pix(0, 0, 255));
        send_pixel(pix(0, 255, 0));
        send_pixel(pix(255, 0, 0));
        send_pixel(pix(0, 255, 255));
        send_pixel(pix(255, 0, 255));
        send_pixel(pix(255, 255, 0));
        send_pixel(pix(0, 0, 1));
        send_pixel(pix(1, 0, 0));
        send_pixel(pix(0, 1, 0));
        send_pixel(pix(10, 10, 200));
        send_pixel(pix(10, 200, 10));
        send_pixel(pix(200, 10, 10));
        send_pixel(pix(0, 128, 255));
        send_pixel(pix(0, 255, 128));
        send_pixel(pix(255, 0, 128));
        send_pixel(pix(128, 0, 255));
        send_pixel(pix(255, 128, 0));
        send_pixel(pix(128, 255, 0));
        send_pixel(pix(1, 254, 255));
        send_pixel(pix(170, 85, 255));
    endtask

    task automatic test_random_pixels(int count);
        repeat (count) send_pixel(rand_pixel());
    endtask

    // Hold the receiver off while the sender keeps offering, so the chain fills
    task automatic test_full_chain();
        hold_asked++;
        repeat (60) send_pixel(rand_pixel());
    endtask

    initial begin
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 16;
        recv_idle_pct = 74;
        test_corners();
        test_random_pixels(PHASE_ITEMS);

        send_idle_pct = 74;
        recv_idle_pct = 16;
        test_random_pixels(PHASE_ITEMS);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_full_chain();
        test_random_pixels(PHASE_ITEMS - 60);

        // drain, then watch for stray beats
        i_valid <= 1'b0;
        while (exp_hsv_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (hsv_mismatches == 0) begin
            $display("PASS rgb_to_hsv_pixel");
        end else begin
            $display("FAIL rgb_to_hsv_pixel");
        end
        $finish;
    end

endmodule
